/* src/geo_pkg.sv */
// ----------------------------------------------------------------------------
// geo_pkg
// Shared types, fixed-point constants and elaboration-time table functions.
// ----------------------------------------------------------------------------
package geo_pkg;

  localparam int FRAC = 40;
  localparam int MUL_LAT = 4;
  localparam int SUB_BITS = 8;
  localparam logic signed [63:0] ONE_Q = 64'sd1 <<< FRAC;
  localparam logic signed [63:0] THREE_Q = 64'sd3 <<< FRAC;
  localparam logic signed [63:0] E2_Q = 64'sd7360548640;
  localparam logic signed [63:0] OMT_Q = ONE_Q - E2_Q;
  localparam logic signed [63:0] SEMI_SUB = 64'sd6378137000 <<< SUB_BITS;
  localparam logic [63:0] PI_Q61 = 64'h6487ED5110B4611A;
  localparam logic signed [63:0] OUT_MAX = (64'sd1 <<< 44) - 64'sd1;
  localparam logic signed [63:0] OUT_MIN = -(64'sd1 <<< 44);

  localparam logic [1:0] REG_LAT = 2'd0;
  localparam logic [1:0] REG_LON = 2'd1;
  localparam logic [1:0] REG_ALT = 2'd2;

  typedef struct packed {
    logic signed [63:0] cl;
    logic signed [63:0] sl;
    logic signed [63:0] co;
    logic signed [63:0] so;
  } trig_t;

  typedef struct packed {
    logic signed [63:0] x;
    logic signed [63:0] y;
    logic signed [63:0] z;
    trig_t              trig;
  } ecef_t;

  function automatic logic signed [63:0] mulq_c(logic signed [63:0] a,
                                                logic signed [63:0] b);
    logic [63:0]  ua;
    logic [63:0]  ub;
    logic [127:0] pr;
    logic [63:0]  res;
    ua = a[63] ? 64'(-a) : 64'(a);
    ub = b[63] ? 64'(-b) : 64'(b);
    pr = ({64'd0, ua} * {64'd0, ub}) + (128'd1 << (FRAC - 1));
    res = (pr[127:103] != '0) ? 64'h7FFF_FFFF_FFFF_FFFF : {1'b0, pr[102:40]};
    return (a[63] != b[63]) ? -$signed(res) : $signed(res);
  endfunction

  function automatic logic signed [63:0] inv_sqrt_c(logic signed [63:0] w,
                                                    logic signed [63:0] y0);
    logic signed [63:0] y;
    logic signed [63:0] t;
    y = y0;
    for (int i = 0; i < 5; i++) begin
      t = THREE_Q - mulq_c(w, mulq_c(y, y));
      y = mulq_c(y, t) >>> 1;
    end
    return y;
  endfunction

  function automatic logic signed [63:0] gain_k(int stages);
    logic [63:0] prod;
    prod = 64'(ONE_Q);
    for (int i = 0; i < stages; i++) begin
      if (2 * i < 63) begin
        prod = prod + (prod >> (2 * i));
      end
    end
    return inv_sqrt_c($signed(prod), (ONE_Q * 6) / 10);
  endfunction

  function automatic logic [63:0] atan_entry(int idx, int angle_bits);
    logic signed [63:0] acc;
    logic [63:0]        term;
    logic [63:0]        rem;
    logic [63:0]        res;
    int                 sh;
    acc = '0;
    res = '0;
    if (idx == 0) begin
      return 64'd1 << (angle_bits - 3);
    end
    for (int k = 0; k < 64; k++) begin
      sh = idx * (2 * k + 1);
      if (sh <= 61) begin
        term = ((64'd1 << 61) >> sh) / 64'(2 * k + 1);
        acc = (k % 2 == 1) ? acc - $signed(term) : acc + $signed(term);
      end
    end
    rem = 64'(acc);
    for (int b = 0; b < angle_bits - 1; b++) begin
      rem = rem << 1;
      res = res << 1;
      if (rem >= PI_Q61) begin
        rem = rem - PI_Q61;
        res = res | 64'd1;
      end
    end
    if ((rem << 1) >= PI_Q61) begin
      res = res + 64'd1;
    end
    return res;
  endfunction

endpackage

/* src/geo_if.sv */
// ----------------------------------------------------------------------------
// geo_if
// Handshake channels for geodetic points, ENU results and register writes.
// ----------------------------------------------------------------------------
interface geo_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] latitude;
  logic signed [31:0] longitude;
  logic signed [30:0] altitude;
  modport source (output valid, latitude, longitude, altitude, input ready);
  modport sink (input valid, latitude, longitude, altitude, output ready);
endinterface

interface geo_out_if;
  logic               valid;
  logic               ready;
  logic signed [44:0] east;
  logic signed [44:0] north;
  logic signed [44:0] up;
  logic               saturated;
  modport source (output valid, east, north, up, saturated, input ready);
  modport sink (input valid, east, north, up, saturated, output ready);
endinterface

interface geo_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* src/geo_mulq.sv */
// ----------------------------------------------------------------------------
// geo_mulq
// Pipelined Q40 multiply, rounded to nearest with ties away from zero.
// ----------------------------------------------------------------------------
module geo_mulq
  import geo_pkg::*;
(
  input  logic               clk_i,
  input  logic               en_i,
  input  logic signed [63:0] a_i,
  input  logic signed [63:0] b_i,
  output logic signed [63:0] p_o
);

  logic         neg_q [3];
  logic [63:0]  ua_q;
  logic [63:0]  ub_q;
  logic [63:0]  pp_q [4];
  logic [127:0] sum_q;
  logic [127:0] rnd;
  logic [63:0]  res;
  logic signed [63:0] p_q;

  always_comb begin
    rnd = sum_q + (128'd1 << (FRAC - 1));
    res = (rnd[127:103] != '0) ? 64'h7FFF_FFFF_FFFF_FFFF : {1'b0, rnd[102:40]};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      neg_q[0] <= a_i[63] ^ b_i[63];
      neg_q[1] <= neg_q[0];
      neg_q[2] <= neg_q[1];
      ua_q <= a_i[63] ? 64'(-a_i) : 64'(a_i);
      ub_q <= b_i[63] ? 64'(-b_i) : 64'(b_i);
      pp_q[0] <= ua_q[31:0] * ub_q[31:0];
      pp_q[1] <= ua_q[31:0] * ub_q[63:32];
      pp_q[2] <= ua_q[63:32] * ub_q[31:0];
      pp_q[3] <= ua_q[63:32] * ub_q[63:32];
      sum_q <= {64'd0, pp_q[0]} + {32'd0, pp_q[1], 32'd0} + {32'd0, pp_q[2], 32'd0}
             + {pp_q[3], 64'd0};
      p_q <= neg_q[2] ? -$signed(res) : $signed(res);
    end
  end

  assign p_o = p_q;

endmodule

/* src/geo_cordic_cell.sv */
// ----------------------------------------------------------------------------
// geo_cordic_cell
// One rotation stage of the sine and cosine chain.
// ----------------------------------------------------------------------------
module geo_cordic_cell
  import geo_pkg::*;
#(
  parameter int ANGLE_BITS = 32,
  parameter int IDX = 0
) (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic signed [63:0]        x_i,
  input  logic signed [63:0]        y_i,
  input  logic signed [ANGLE_BITS:0] z_i,
  input  logic [1:0]                q_i,
  output logic signed [63:0]        x_o,
  output logic signed [63:0]        y_o,
  output logic signed [ANGLE_BITS:0] z_o,
  output logic [1:0]                q_o
);

  localparam logic signed [ANGLE_BITS:0] Atan =
    (ANGLE_BITS + 1)'(atan_entry(IDX, ANGLE_BITS));

  logic signed [63:0]         x_q;
  logic signed [63:0]         y_q;
  logic signed [ANGLE_BITS:0] z_q;
  logic [1:0]                 q_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (!z_i[ANGLE_BITS]) begin
        x_q <= x_i - (y_i >>> IDX);
        y_q <= y_i + (x_i >>> IDX);
        z_q <= z_i - Atan;
      end else begin
        x_q <= x_i + (y_i >>> IDX);
        y_q <= y_i - (x_i >>> IDX);
        z_q <= z_i + Atan;
      end
      q_q <= q_i;
    end
  end

  assign x_o = x_q;
  assign y_o = y_q;
  assign z_o = z_q;
  assign q_o = q_q;

endmodule

/* src/geo_newton.sv */
// ----------------------------------------------------------------------------
// geo_newton
// One Newton step of the inverse square root, y' = y (3 - w y^2) / 2.
// ----------------------------------------------------------------------------
module geo_newton
  import geo_pkg::*;
(
  input  logic               clk_i,
  input  logic               en_i,
  input  logic signed [63:0] w_i,
  input  logic signed [63:0] y_i,
  output logic signed [63:0] w_o,
  output logic signed [63:0] y_o
);

  localparam int WDly = 3 * MUL_LAT + 2;
  localparam int YDly = 2 * MUL_LAT + 1;

  logic signed [63:0] w_q [WDly];
  logic signed [63:0] yd_q [YDly];
  logic signed [63:0] yy;
  logic signed [63:0] wy;
  logic signed [63:0] m;
  logic signed [63:0] t_q;
  logic signed [63:0] y_q;

  geo_mulq u_sq (.clk_i, .en_i, .a_i(y_i), .b_i(y_i), .p_o(yy));
  geo_mulq u_wy (.clk_i, .en_i, .a_i(w_q[MUL_LAT-1]), .b_i(yy), .p_o(wy));
  geo_mulq u_m (.clk_i, .en_i, .a_i(yd_q[YDly-1]), .b_i(t_q), .p_o(m));

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      w_q[0] <= w_i;
      for (int k = 1; k < WDly; k++) w_q[k] <= w_q[k-1];
      yd_q[0] <= y_i;
      for (int k = 1; k < YDly; k++) yd_q[k] <= yd_q[k-1];
      t_q <= THREE_Q - wy;
      y_q <= m >>> 1;
    end
  end

  assign w_o = w_q[WDly-1];
  assign y_o = y_q;

endmodule

/* src/geo_ecef.sv */
// ----------------------------------------------------------------------------
// geo_ecef
// Geodetic point to earth-centred coordinates in units of 2^-8 mm.
// ----------------------------------------------------------------------------
module geo_ecef
  import geo_pkg::*;
#(
  parameter int ANGLE_BITS = 32,
  parameter int CORDIC_STAGES = 32
) (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic [31:0]        lat_i,
  input  logic [31:0]        lon_i,
  input  logic [30:0]        alt_i,
  output ecef_t              pt_o
);

  localparam int M = MUL_LAT;
  localparam int TC = CORDIC_STAGES + 1;
  localparam int TW = TC + 2 * M + 1;
  localparam int TY = TW + 5 * (3 * M + 2);
  localparam int TN = TY + M;
  localparam int TR = TN + 1;
  localparam int TRC = TR + M;
  localparam int TX = TRC + M;
  localparam int TNZ = TN + M;
  localparam int TZH = TNZ + 1;
  localparam logic signed [63:0] GainK = gain_k(CORDIC_STAGES);

  logic signed [63:0]         lx [CORDIC_STAGES+1];
  logic signed [63:0]         ly [CORDIC_STAGES+1];
  logic signed [ANGLE_BITS:0] lz [CORDIC_STAGES+1];
  logic [1:0]                 lq [CORDIC_STAGES+1];
  logic signed [63:0]         ox [CORDIC_STAGES+1];
  logic signed [63:0]         oy [CORDIC_STAGES+1];
  logic signed [ANGLE_BITS:0] oz [CORDIC_STAGES+1];
  logic [1:0]                 oq [CORDIC_STAGES+1];
  logic [ANGLE_BITS-1:0]      lat_ph;
  logic [ANGLE_BITS-1:0]      lon_ph;

  trig_t              trig_q;
  trig_t              tdl_q [TX-TC];
  logic [30:0]        alt_q [TNZ];
  logic signed [63:0] s2, t1, w_q, n, rc, nz, r_q, zh_q, px, py, pz;
  logic signed [63:0] nw [6];
  logic signed [63:0] ny [6];
  logic signed [63:0] h_n, h_nz;

  function automatic logic signed [63:0] clip1(logic signed [63:0] v);
    return (v > ONE_Q) ? ONE_Q : ((v < -ONE_Q) ? -ONE_Q : v);
  endfunction

  assign lat_ph = ANGLE_BITS'({lat_i, 8'd0} >> (40 - ANGLE_BITS));
  assign lon_ph = ANGLE_BITS'({lon_i, 8'd0} >> (40 - ANGLE_BITS));
  assign lx[0] = GainK;
  assign ly[0] = '0;
  assign lz[0] = $signed({3'd0, lat_ph[ANGLE_BITS-3:0]});
  assign lq[0] = lat_ph[ANGLE_BITS-1:ANGLE_BITS-2];
  assign ox[0] = GainK;
  assign oy[0] = '0;
  assign oz[0] = $signed({3'd0, lon_ph[ANGLE_BITS-3:0]});
  assign oq[0] = lon_ph[ANGLE_BITS-1:ANGLE_BITS-2];

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
    geo_cordic_cell #(.ANGLE_BITS(ANGLE_BITS), .IDX(i)) u_lat (
      .clk_i, .en_i, .x_i(lx[i]), .y_i(ly[i]), .z_i(lz[i]), .q_i(lq[i]),
      .x_o(lx[i+1]), .y_o(ly[i+1]), .z_o(lz[i+1]), .q_o(lq[i+1])
    );
    geo_cordic_cell #(.ANGLE_BITS(ANGLE_BITS), .IDX(i)) u_lon (
      .clk_i, .en_i, .x_i(ox[i]), .y_i(oy[i]), .z_i(oz[i]), .q_i(oq[i]),
      .x_o(ox[i+1]), .y_o(oy[i+1]), .z_o(oz[i+1]), .q_o(oq[i+1])
    );
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      unique case (lq[CORDIC_STAGES])
        2'd0: begin
          trig_q.cl <= clip1(lx[CORDIC_STAGES]);
          trig_q.sl <= clip1(ly[CORDIC_STAGES]);
        end
        2'd1: begin
          trig_q.cl <= -clip1(ly[CORDIC_STAGES]);
          trig_q.sl <= clip1(lx[CORDIC_STAGES]);
        end
        2'd2: begin
          trig_q.cl <= -clip1(lx[CORDIC_STAGES]);
          trig_q.sl <= -clip1(ly[CORDIC_STAGES]);
        end
        default: begin
          trig_q.cl <= clip1(ly[CORDIC_STAGES]);
          trig_q.sl <= -clip1(lx[CORDIC_STAGES]);
        end
      endcase
      unique case (oq[CORDIC_STAGES])
        2'd0: begin
          trig_q.co <= clip1(ox[CORDIC_STAGES]);
          trig_q.so <= clip1(oy[CORDIC_STAGES]);
        end
        2'd1: begin
          trig_q.co <= -clip1(oy[CORDIC_STAGES]);
          trig_q.so <= clip1(ox[CORDIC_STAGES]);
        end
        2'd2: begin
          trig_q.co <= -clip1(ox[CORDIC_STAGES]);
          trig_q.so <= -clip1(oy[CORDIC_STAGES]);
        end
        default: begin
          trig_q.co <= clip1(oy[CORDIC_STAGES]);
          trig_q.so <= -clip1(ox[CORDIC_STAGES]);
        end
      endcase
      tdl_q[0] <= trig_q;
      for (int k = 1; k < TX - TC; k++) tdl_q[k] <= tdl_q[k-1];
      alt_q[0] <= alt_i;
      for (int k = 1; k < TNZ; k++) alt_q[k] <= alt_q[k-1];
      w_q <= ONE_Q - t1;
      r_q <= n + h_n;
      zh_q <= nz + h_nz;
    end
  end

  assign h_n = $signed({{25{alt_q[TN-1][30]}}, alt_q[TN-1], 8'd0});
  assign h_nz = $signed({{25{alt_q[TNZ-1][30]}}, alt_q[TNZ-1], 8'd0});

  geo_mulq u_s2 (.clk_i, .en_i, .a_i(trig_q.sl), .b_i(trig_q.sl), .p_o(s2));
  geo_mulq u_t1 (.clk_i, .en_i, .a_i(E2_Q), .b_i(s2), .p_o(t1));

  assign nw[0] = w_q;
  assign ny[0] = ONE_Q;
  for (genvar j = 0; j < 5; j++) begin : g_newton
    geo_newton u_step (
      .clk_i, .en_i, .w_i(nw[j]), .y_i(ny[j]), .w_o(nw[j+1]), .y_o(ny[j+1])
    );
  end

  geo_mulq u_n (.clk_i, .en_i, .a_i(SEMI_SUB), .b_i(ny[5]), .p_o(n));
  geo_mulq u_rc (.clk_i, .en_i, .a_i(r_q), .b_i(tdl_q[TR-TC-1].cl), .p_o(rc));
  geo_mulq u_x (.clk_i, .en_i, .a_i(rc), .b_i(tdl_q[TRC-TC-1].co), .p_o(px));
  geo_mulq u_y (.clk_i, .en_i, .a_i(rc), .b_i(tdl_q[TRC-TC-1].so), .p_o(py));
  geo_mulq u_nz (.clk_i, .en_i, .a_i(n), .b_i(OMT_Q), .p_o(nz));
  geo_mulq u_z (.clk_i, .en_i, .a_i(zh_q), .b_i(tdl_q[TZH-TC-1].sl), .p_o(pz));

  assign pt_o.x = px;
  assign pt_o.y = py;
  assign pt_o.z = pz;
  assign pt_o.trig = tdl_q[TX-TC-1];

endmodule

/* src/geodetic_to_local_enu.sv */
// ----------------------------------------------------------------------------
// geodetic_to_local_enu
// Geodetic point to east, north and up offsets from a reference point.
// ----------------------------------------------------------------------------
// Points arrive on in_i and results leave on out_o, one result per item.
// The reference point is written through cfg_i (index 0 latitude, 1 longitude,
// 2 altitude); cfg_i is always ready and writes to other indexes are ignored.
// The datapath is a fixed pipeline that takes one item in every cycle. Its
// depth is set by the chain of CORDIC cells and its quadrant register, the
// sin^2 and e2 products, the five Newton steps of the inverse square root,
// the radius and ECEF products and the rotation into the local frame with
// the output register.
// The reference point runs through a second copy of the front end alongside
// every item, so new register values apply to the next item accepted.
// The last stage is the output register. While it holds an item that the
// receiver has not taken, the whole pipeline holds and in_i.ready is low; it
// rises again in the cycle the item is taken.
// Reset clears the registers to zero and empties the pipeline.
// ----------------------------------------------------------------------------
module geodetic_to_local_enu
  import geo_pkg::*;
#(
  parameter int ANGLE_BITS = 32,
  parameter int CORDIC_STAGES = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  geo_in_if.sink    in_i,
  geo_out_if.source out_o,
  geo_cfg_if.sink   cfg_i
);

  localparam int M = MUL_LAT;
  localparam int LE = CORDIC_STAGES + 1 + 2 * M + 1 + 5 * (3 * M + 2) + 3 * M + 1;
  localparam int LTOT = LE + 2 * M + 3;

  logic               en;
  logic [31:0]        ref_lat_q;
  logic [31:0]        ref_lon_q;
  logic [30:0]        ref_alt_q;
  logic               vld_q [LTOT];
  ecef_t              pt, rf;
  logic signed [63:0] dx_q, dy_q, dz_q;
  trig_t              tr_q [M+1];
  logic signed [63:0] dzd_q [M];
  logic signed [63:0] m_cdx, m_sdy, m_cdy, m_sdx;
  logic signed [63:0] t_q, e_q, dz2_q;
  trig_t              tr2_q;
  logic signed [63:0] ed_q [M];
  logic signed [63:0] m_cdz, m_st, m_ct, m_sdz;
  logic [45:0]        oe, on, ou;
  logic signed [44:0] east_q, north_q, up_q;
  logic               sat_q;

  function automatic logic [45:0] emit(logic signed [63:0] v);
    logic [63:0]        mag;
    logic signed [63:0] r;
    mag = v[63] ? 64'(-v) : 64'(v);
    mag = (mag + 64'd128) >> SUB_BITS;
    r = v[63] ? -$signed(mag) : $signed(mag);
    if (r > OUT_MAX) return {1'b1, OUT_MAX[44:0]};
    if (r < OUT_MIN) return {1'b1, OUT_MIN[44:0]};
    return {1'b0, r[44:0]};
  endfunction

  assign en = !vld_q[LTOT-1] || out_o.ready;
  assign in_i.ready = en;
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_lat_q <= '0;
      ref_lon_q <= '0;
      ref_alt_q <= '0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        REG_LAT: ref_lat_q <= cfg_i.data;
        REG_LON: ref_lon_q <= cfg_i.data;
        REG_ALT: ref_alt_q <= cfg_i.data[30:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < LTOT; k++) vld_q[k] <= 1'b0;
    end else if (en) begin
      vld_q[0] <= in_i.valid;
      for (int k = 1; k < LTOT; k++) vld_q[k] <= vld_q[k-1];
    end
  end

  geo_ecef #(.ANGLE_BITS(ANGLE_BITS), .CORDIC_STAGES(CORDIC_STAGES)) u_pt (
    .clk_i, .en_i(en), .lat_i(in_i.latitude), .lon_i(in_i.longitude),
    .alt_i(in_i.altitude), .pt_o(pt)
  );

  geo_ecef #(.ANGLE_BITS(ANGLE_BITS), .CORDIC_STAGES(CORDIC_STAGES)) u_ref (
    .clk_i, .en_i(en), .lat_i(ref_lat_q), .lon_i(ref_lon_q),
    .alt_i(ref_alt_q), .pt_o(rf)
  );

  geo_mulq u_cdx (.clk_i, .en_i(en), .a_i(tr_q[0].co), .b_i(dx_q), .p_o(m_cdx));
  geo_mulq u_sdy (.clk_i, .en_i(en), .a_i(tr_q[0].so), .b_i(dy_q), .p_o(m_sdy));
  geo_mulq u_cdy (.clk_i, .en_i(en), .a_i(tr_q[0].co), .b_i(dy_q), .p_o(m_cdy));
  geo_mulq u_sdx (.clk_i, .en_i(en), .a_i(tr_q[0].so), .b_i(dx_q), .p_o(m_sdx));
  geo_mulq u_cdz (.clk_i, .en_i(en), .a_i(tr2_q.cl), .b_i(dz2_q), .p_o(m_cdz));
  geo_mulq u_st (.clk_i, .en_i(en), .a_i(tr2_q.sl), .b_i(t_q), .p_o(m_st));
  geo_mulq u_ct (.clk_i, .en_i(en), .a_i(tr2_q.cl), .b_i(t_q), .p_o(m_ct));
  geo_mulq u_sdz (.clk_i, .en_i(en), .a_i(tr2_q.sl), .b_i(dz2_q), .p_o(m_sdz));

  assign oe = emit(ed_q[M-1]);
  assign on = emit(m_cdz - m_st);
  assign ou = emit(m_ct + m_sdz);

  always_ff @(posedge clk_i) begin
    if (en) begin
      dx_q <= pt.x - rf.x;
      dy_q <= pt.y - rf.y;
      dz_q <= pt.z - rf.z;
      tr_q[0] <= rf.trig;
      for (int k = 1; k <= M; k++) tr_q[k] <= tr_q[k-1];
      dzd_q[0] <= dz_q;
      for (int k = 1; k < M; k++) dzd_q[k] <= dzd_q[k-1];
      t_q <= m_cdx + m_sdy;
      e_q <= m_cdy - m_sdx;
      dz2_q <= dzd_q[M-1];
      tr2_q <= tr_q[M];
      ed_q[0] <= e_q;
      for (int k = 1; k < M; k++) ed_q[k] <= ed_q[k-1];
      east_q <= oe[44:0];
      north_q <= on[44:0];
      up_q <= ou[44:0];
      sat_q <= oe[45] | on[45] | ou[45];
    end
  end

  assign out_o.valid = vld_q[LTOT-1];
  assign out_o.east = east_q;
  assign out_o.north = north_q;
  assign out_o.up = up_q;
  assign out_o.saturated = sat_q;

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_o.valid |-> in_i.ready)
    else $error("input not ready while output register is empty");

  a_sat_at_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.saturated |->
      (out_o.east == OUT_MAX[44:0]) || (out_o.east == OUT_MIN[44:0]) ||
      (out_o.north == OUT_MAX[44:0]) || (out_o.north == OUT_MIN[44:0]) ||
      (out_o.up == OUT_MAX[44:0]) || (out_o.up == OUT_MIN[44:0]))
    else $error("saturated flag set with no field at a bound");

  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.ready |=> !$past(in_i.ready) && vld_q[LTOT-1])
    else $error("pipeline advanced while the output was stalled");

endmodule

/* dv/geo_test_if.sv */
// ----------------------------------------------------------------------------
// geo_test_if
// Clock and reset generation shared by the ENU testbench.
// ----------------------------------------------------------------------------
// The block's channel interfaces come from the RTL; this file holds the small
// clock and reset source that drives them, so the top module stays focused on
// stimulus and checking.
// ----------------------------------------------------------------------------
interface geo_clk_if;
  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #4 clk = ~clk;
  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
  end
endinterface

/* dv/geodetic_to_local_enu_test.sv */
// ----------------------------------------------------------------------------
// geodetic_to_local_enu_test
// Self-checking testbench for the geodetic to local ENU converter.
// ----------------------------------------------------------------------------
// Geodetic points are pushed through the block in bursts with random gaps,
// while the result side stalls on its own pattern. Each accepted point is run
// through a fixed-point predictor of the WGS84 conversion and the expected
// offsets are queued; results are compared field by field in order. Several
// reference points are written between phases, including the extremes.
// ----------------------------------------------------------------------------
module geodetic_to_local_enu_test;
  import geo_pkg::*;

  localparam int ANG_BITS = 32;
  localparam int STAGES = 32;
  localparam int LATENCY = STAGES + 104;
  localparam int WATCHDOG = 20000;
  localparam int N_RANDOM = 1280;
  localparam logic [1:0] REG_NONE = 2'd3;

  typedef struct {
    logic signed [44:0] east;
    logic signed [44:0] north;
    logic signed [44:0] up;
    logic               saturated;
  } enu_t;

  typedef struct {
    logic signed [31:0] lat;
    logic signed [31:0] lon;
    logic signed [30:0] alt;
    logic               known;
    logic               sat;
  } point_row_t;

  typedef struct {
    logic signed [63:0] cl, sl, co, so, x, y, z;
  } ecef_pt_t;

  logic clk_i;
  logic rst_ni;

  geo_clk_if clk_src ();
  geo_in_if  pt_if ();
  geo_out_if enu_if ();
  geo_cfg_if cfg_if ();

  assign clk_i = clk_src.clk;
  assign rst_ni = clk_src.rst_n;

  geodetic_to_local_enu #(
    .ANGLE_BITS(ANG_BITS),
    .CORDIC_STAGES(STAGES)
  ) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (pt_if),
    .out_o (enu_if),
    .cfg_i (cfg_if)
  );

  logic signed [63:0] atan_lut[STAGES];
  logic signed [63:0] cordic_gain;
  logic signed [31:0] ref_lat_q, ref_lon_q;
  logic signed [30:0] ref_alt_q;
  enu_t               enu_expected[$];
  int                 fail_count = 0;
  int                 row_fail = 0;
  int                 idle_cycles = 0;
  bit                 stim_done = 1'b0;
  bit                 hold_off = 1'b0;

  function automatic logic signed [63:0] mul_q40(logic signed [63:0] a,
                                                 logic signed [63:0] b);
    logic [63:0]  ma;
    logic [63:0]  mb;
    logic [127:0] prod;
    logic [63:0]  mag;
    ma = a[63] ? 64'(-a) : 64'(a);
    mb = b[63] ? 64'(-b) : 64'(b);
    prod = {64'd0, ma} * {64'd0, mb} + (128'd1 << 39);
    if (prod[127:103] != '0) mag = 64'h7FFF_FFFF_FFFF_FFFF;
    else mag = {1'b0, prod[102:40]};
    return (a[63] != b[63]) ? -$signed(mag) : $signed(mag);
  endfunction

  function automatic logic signed [63:0] newton_rsqrt(logic signed [63:0] w,
                                                      logic signed [63:0] seed);
    logic signed [63:0] est;
    est = seed;
    repeat (5) est = mul_q40(est, THREE_Q - mul_q40(w, mul_q40(est, est))) >>> 1;
    return est;
  endfunction

  function automatic void build_cordic_constants();
    logic [63:0]        prod;
    logic signed [63:0] acc;
    logic [63:0]        rem;
    logic [63:0]        res;
    int                 sh;
    prod = 64'(ONE_Q);
    for (int i = 0; i < STAGES; i++) if (2 * i < 63) prod = prod + (prod >> (2 * i));
    cordic_gain = newton_rsqrt($signed(prod), (ONE_Q * 6) / 10);
    atan_lut[0] = 64'sd1 <<< (ANG_BITS - 3);
    for (int i = 1; i < STAGES; i++) begin
      acc = '0;
      res = '0;
      for (int k = 0; k < 32; k++) begin
        sh = i * (2 * k + 1);
        if (sh <= 61) begin
          if (k % 2 == 1) acc = acc - $signed(((64'd1 << 61) >> sh) / 64'(2 * k + 1));
          else acc = acc + $signed(((64'd1 << 61) >> sh) / 64'(2 * k + 1));
        end
      end
      rem = 64'(acc);
      for (int b = 0; b < ANG_BITS - 1; b++) begin
        rem = rem << 1;
        res = res << 1;
        if (rem >= PI_Q61) begin
          rem = rem - PI_Q61;
          res = res | 64'd1;
        end
      end
      if ((rem << 1) >= PI_Q61) res = res + 64'd1;
      atan_lut[i] = $signed(res);
    end
  endfunction

  function automatic logic signed [63:0] clamp_unit(logic signed [63:0] v);
    if (v > ONE_Q) return ONE_Q;
    if (v < -ONE_Q) return -ONE_Q;
    return v;
  endfunction

  function automatic void rotate_angle(logic [31:0] ang, output logic signed [63:0] c,
                                       output logic signed [63:0] s);
    logic [63:0]        ph;
    logic [1:0]         quad;
    logic signed [63:0] x, y, z, nx;
    ph = ({32'd0, ang} << 8) >> (40 - ANG_BITS);
    quad = ph[ANG_BITS-1 -: 2];
    z = $signed(ph & ((64'd1 << (ANG_BITS - 2)) - 1));
    x = cordic_gain;
    y = '0;
    for (int i = 0; i < STAGES; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i); y = y + (x >>> i); z = z - atan_lut[i];
      end else begin
        nx = x + (y >>> i); y = y - (x >>> i); z = z + atan_lut[i];
      end
      x = nx;
    end
    x = clamp_unit(x);
    y = clamp_unit(y);
    case (quad)
      2'd0: begin c = x; s = y; end
      2'd1: begin c = -y; s = x; end
      2'd2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
  endfunction

  function automatic ecef_pt_t point_to_ecef(logic [31:0] lat, logic [31:0] lon,
                                             logic signed [30:0] alt);
    ecef_pt_t           g;
    logic signed [63:0] n, h, rc;
    rotate_angle(lat, g.cl, g.sl);
    rotate_angle(lon, g.co, g.so);
    n = mul_q40(SEMI_SUB, newton_rsqrt(ONE_Q - mul_q40(E2_Q, mul_q40(g.sl, g.sl)), ONE_Q));
    h = 64'(alt) <<< SUB_BITS;
    rc = mul_q40(n + h, g.cl);
    g.x = mul_q40(rc, g.co);
    g.y = mul_q40(rc, g.so);
    g.z = mul_q40(mul_q40(n, OMT_Q) + h, g.sl);
    return g;
  endfunction

  function automatic logic signed [44:0] to_mm(logic signed [63:0] v, ref logic sat);
    logic [63:0]        mag;
    logic signed [63:0] r;
    mag = v[63] ? 64'(-v) : 64'(v);
    mag = (mag + 64'd128) >> SUB_BITS;
    r = v[63] ? -$signed(mag) : $signed(mag);
    if (r > OUT_MAX) begin r = OUT_MAX; sat = 1'b1; end
    if (r < OUT_MIN) begin r = OUT_MIN; sat = 1'b1; end
    return r[44:0];
  endfunction

  function automatic enu_t predict_enu(logic [31:0] lat, logic [31:0] lon,
                                       logic signed [30:0] alt);
    ecef_pt_t           p, o;
    logic signed [63:0] dx, dy, dz, t;
    logic               sat;
    enu_t               r;
    p = point_to_ecef(lat, lon, alt);
    o = point_to_ecef(ref_lat_q, ref_lon_q, ref_alt_q);
    dx = p.x - o.x;
    dy = p.y - o.y;
    dz = p.z - o.z;
    sat = 1'b0;
    t = mul_q40(o.co, dx) + mul_q40(o.so, dy);
    r.east = to_mm(mul_q40(o.co, dy) - mul_q40(o.so, dx), sat);
    r.north = to_mm(mul_q40(o.cl, dz) - mul_q40(o.sl, t), sat);
    r.up = to_mm(mul_q40(o.cl, t) + mul_q40(o.sl, dz), sat);
    r.saturated = sat;
    return r;
  endfunction

  task automatic write_reg(logic [1:0] idx, logic [31:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= value;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    case (idx)
      REG_LAT: ref_lat_q = value;
      REG_LON: ref_lon_q = value;
      REG_ALT: ref_alt_q = value[30:0];
      default: ;
    endcase
  endtask

  task automatic drain_and_settle();
    pt_if.valid <= 1'b0;
    while (enu_expected.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
  endtask

  // Sends one item; when gap is set, a random gap follows it.
  task automatic send_point(logic signed [31:0] lat, logic signed [31:0] lon,
                            logic signed [30:0] alt, bit gap);
    pt_if.valid <= 1'b1;
    pt_if.latitude <= lat;
    pt_if.longitude <= lon;
    pt_if.altitude <= alt;
    do @(posedge clk_i); while (!pt_if.ready);
    enu_expected.push_back(predict_enu(lat, lon, alt));
    if (gap) begin
      pt_if.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  task automatic random_points(int count);
    int burst;
    burst = 0;
    for (int i = 0; i < count; i++) begin
      if (burst == 0) burst = $urandom_range(1, 40);
      burst--;
      send_point($signed($urandom_range(0, 32'h8000_0000)) - 32'sh4000_0000,
                 ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 32'hFFFF) << 16,
                 ($urandom_range(0, 7) == 0) ? 31'($urandom)
                   : 31'(int'($urandom_range(0, 1010000000)) - 10000000),
                 burst == 0 && $urandom_range(0, 2) != 0);
    end
  endtask

  point_row_t directed_rows[] = '{
    '{32'sh0000_0000, 32'sh0000_0000, 31'sd0, 1'b1, 1'b0},
    '{32'sh4000_0000, 32'sh0000_0000, 31'sd0, 1'b0, 1'b0},
    '{-32'sh4000_0000, 32'sh0000_0000, 31'sd0, 1'b0, 1'b0},
    '{32'sh0000_0000, 32'sh7FFF_FFFF, 31'sd0, 1'b0, 1'b0},
    '{32'sh0000_0000, -32'sh8000_0000, 31'sd0, 1'b0, 1'b0},
    '{32'sh0000_0000, 32'sh4000_0000, 31'sd1000000000, 1'b0, 1'b0},
    '{32'sh0000_0000, -32'sh4000_0000, -31'sd10000000, 1'b0, 1'b0},
    '{32'sh7FFF_FFFF, 32'sh0000_0000, 31'sd0, 1'b0, 1'b0},
    '{-32'sh8000_0000, 32'sh1234_5678, 31'sd0, 1'b0, 1'b0},
    '{32'sh6000_0000, 32'shA000_0000, 31'sd500, 1'b0, 1'b0},
    '{32'sh2000_0000, 32'shFFFF_FFFF, 31'sh3FFF_FFFF, 1'b0, 1'b0},
    '{32'sh0000_0001, 32'sh0000_0001, -31'sh4000_0000, 1'b0, 1'b0},
    '{32'shAAAA_AAAA, 32'h5555_5555, 31'h2AAA_AAAA, 1'b0, 1'b0},
    '{32'sh5555_5555, 32'hAAAA_AAAA, 31'h5555_5555, 1'b0, 1'b0},
    '{32'sh0000_0000, 32'sh0000_0000, 31'sh3FFF_FFFF, 1'b0, 1'b0}
  };

  // Receiver stall pattern, with a long hold-off when requested.
  always @(posedge clk_i) begin
    if (!rst_ni || hold_off) enu_if.ready <= 1'b0;
    else enu_if.ready <= ($urandom_range(0, 9) < 7) || $urandom_range(0, 1);
  end

  always @(posedge clk_i) begin
    enu_t exp_r;
    if (rst_ni) begin
      if ((pt_if.valid && pt_if.ready) || (enu_if.valid && enu_if.ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (enu_if.valid && enu_if.ready) begin
        if (enu_expected.size() == 0) begin
          $error("result with no expectation: east %0d", enu_if.east);
          fail_count++;
        end else begin
          exp_r = enu_expected.pop_front();
          if (enu_if.east !== exp_r.east) begin
            $error("east expected %0d actual %0d", exp_r.east, enu_if.east);
            fail_count++;
          end
          if (enu_if.north !== exp_r.north) begin
            $error("north expected %0d actual %0d", exp_r.north, enu_if.north);
            fail_count++;
          end
          if (enu_if.up !== exp_r.up) begin
            $error("up expected %0d actual %0d", exp_r.up, enu_if.up);
            fail_count++;
          end
          if (enu_if.saturated !== exp_r.saturated) begin
            $error("saturated expected %0d actual %0d", exp_r.saturated,
                   enu_if.saturated);
            fail_count++;
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (idle_cycles >= WATCHDOG) begin
      $display("geodetic_to_local_enu_test failed");
      $finish;
    end
  end

  initial begin
    enu_t last;
    pt_if.valid = 1'b0;
    pt_if.latitude = '0;
    pt_if.longitude = '0;
    pt_if.altitude = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = REG_LAT;
    cfg_if.data = '0;
    ref_lat_q = '0;
    ref_lon_q = '0;
    ref_alt_q = '0;
    build_cordic_constants();
    wait (rst_ni === 1'b1);
    @(posedge clk_i);

    // At reset the reference is the origin point, so that point maps to zero.
    foreach (directed_rows[i]) begin
      send_point(directed_rows[i].lat, directed_rows[i].lon, directed_rows[i].alt,
                 i % 3 == 2);
      if (directed_rows[i].known) begin
        last = enu_expected[$];
        if (last.east != 45'sd0 || last.north != 45'sd0 || last.up != 45'sd0 ||
            last.saturated != directed_rows[i].sat) begin
          $error("origin row predicted off zero");
          row_fail++;
        end
      end
    end
    drain_and_settle();

    // Let the output back up so the pipeline fills and stalls its input.
    fork
      begin
        hold_off = 1'b1;
        repeat (LATENCY * 3) @(posedge clk_i);
        hold_off = 1'b0;
      end
      random_points(220);
    join
    drain_and_settle();

    write_reg(REG_LAT, 32'h4000_0000);
    write_reg(REG_LON, 32'h7FFF_FFFF);
    write_reg(REG_ALT, 32'd1000000000);
    write_reg(REG_NONE, 32'hFFFF_FFFF);
    random_points(N_RANDOM / 4);
    drain_and_settle();

    write_reg(REG_LAT, 32'hC000_0000);
    write_reg(REG_LON, 32'h8000_0000);
    write_reg(REG_ALT, 32'(-10000000));
    random_points(N_RANDOM / 4);
    drain_and_settle();

    write_reg(REG_LAT, 32'h1C71_C71C);
    write_reg(REG_LON, 32'hF000_1234);
    write_reg(REG_ALT, 32'h7FFF_FFFF);
    random_points(N_RANDOM / 4);
    drain_and_settle();

    write_reg(REG_LAT, $urandom_range(0, 32'h8000_0000) - 32'h4000_0000);
    write_reg(REG_LON, $urandom);
    write_reg(REG_ALT, $urandom_range(0, 1000000));
    random_points(N_RANDOM / 4 - 220);
    drain_and_settle();

    if (fail_count == 0 && row_fail == 0) begin
      $display("geodetic_to_local_enu_test passed");
    end else begin
      $display("geodetic_to_local_enu_test failed");
    end
    $finish;
  end
endmodule
